// File: hdl/projected_gauss_seidel_solver_assert.svh
// Assertion macros for the projected Gauss-Seidel solver.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef PROJECTED_GAUSS_SEIDEL_SOLVER_ASSERT_SVH
`define PROJECTED_GAUSS_SEIDEL_SOLVER_ASSERT_SVH
`ifndef SYNTHESIS
`define PGS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PGS_ASSERT_IMP(lbl, ante, cons, msg)
`define PGS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/pgs_pkg.sv
// Shared constants, types and fixed-point helpers of the Gauss-Seidel solver.
// No dependencies.
package pgs_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_UNKNOWNS = 16;
  localparam int IDX_BITS     = 4;
  localparam int SIZE_BITS    = 5;
  localparam int ITER_BITS    = 10;
  localparam int DELTA_BITS   = 31;
  localparam int MODE_BITS    = 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int ACC_BITS     = 38;
  localparam int DVD_BITS     = ACC_BITS + FRAC_BITS;
  localparam int CNT_BITS     = 6;
  localparam int PROD_BITS    = 2 * VALUE_BITS;
  localparam int SATIN_BITS   = PROD_BITS - FRAC_BITS;

  localparam logic [VALUE_BITS-1:0] MIN_SCALE = 32'd66;

  localparam logic [ITER_BITS-1:0]  RST_MAX_ITER = 10'd128;
  localparam logic [DELTA_BITS-1:0] RST_MIN_DELTA = 31'd6554;
  localparam logic [SIZE_BITS-1:0]  RST_SIZE = 5'd16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_ITER  = 2'd0,
    CFG_MIN_DELTA = 2'd1,
    CFG_CLAMP_EN  = 2'd2,
    CFG_SIZE      = 2'd3
  } cfg_idx_e;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOAD_MAT = 2'd0,
    MODE_LOAD_ROW = 2'd1,
    MODE_SOLVE    = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef struct packed {
    logic                  start;
    logic [ACC_BITS-1:0]   num_mag;
    logic [VALUE_BITS-1:0] den_mag;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic                  ovf;
    logic [VALUE_BITS-1:0] quot;
  } div_rsp_t;

  function automatic logic [VALUE_BITS-1:0] mag_of(input logic signed [VALUE_BITS-1:0] v);
    mag_of = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  // Apply sign to a magnitude and saturate to the signed value range.
  function automatic logic signed [VALUE_BITS-1:0] sat_val(input logic [SATIN_BITS-1:0] m,
                                                           input logic neg);
    logic [SATIN_BITS-1:0] lim;
    lim = {{(SATIN_BITS-VALUE_BITS){1'b0}}, 1'b1, {(VALUE_BITS-1){1'b0}}};
    if (neg) begin
      if (m > lim) sat_val = {1'b1, {(VALUE_BITS-1){1'b0}}};
      else sat_val = ~m[VALUE_BITS-1:0] + 1'b1;
    end else begin
      if (m >= lim) sat_val = {1'b0, {(VALUE_BITS-1){1'b1}}};
      else sat_val = m[VALUE_BITS-1:0];
    end
  endfunction

endpackage

// File: hdl/projected_gauss_seidel_solver.sv
// Projected Gauss-Seidel solver, Q16.16, up to 16 unknowns, top level.
// Load words are taken whenever the block is idle. A solve word takes, per sweep, n rows
// (the products on the shared multiplier, then the divider, which a zero pivot skips),
// then n result words; the block takes no input until done.
// Reset clears control state and registers to defaults; stores are undefined.
// Depends on pgs_pkg, pgs_ram, pgs_div and projected_gauss_seidel_solver_assert.svh.
`include "projected_gauss_seidel_solver_assert.svh"
module projected_gauss_seidel_solver (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pgs_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [pgs_pkg::DELTA_BITS-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [pgs_pkg::MODE_BITS-1:0]        mode_i,
  input  logic [pgs_pkg::IDX_BITS-1:0]         row_i,
  input  logic [pgs_pkg::IDX_BITS-1:0]         col_i,
  input  logic signed [pgs_pkg::VALUE_BITS-1:0] matrix_value_i,
  input  logic signed [pgs_pkg::VALUE_BITS-1:0] rhs_value_i,
  input  logic signed [pgs_pkg::VALUE_BITS-1:0] limit_low_i,
  input  logic signed [pgs_pkg::VALUE_BITS-1:0] limit_high_i,
  input  logic signed [pgs_pkg::VALUE_BITS-1:0] initial_lambda_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [pgs_pkg::IDX_BITS-1:0]         index_o,
  output logic signed [pgs_pkg::VALUE_BITS-1:0] lambda_value_o,
  output logic                                 converged_o,
  output logic [pgs_pkg::ITER_BITS-1:0]        iterations_used_o,
  output logic                                 zero_pivot_o,
  output logic                                 last_o
);
  import pgs_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_ROW      = 14'b00000000000010,
    S_ROW_INIT = 14'b00000000000100,
    S_MAC_ADDR = 14'b00000000001000,
    S_MAC_MUL  = 14'b00000000010000,
    S_MAC_ACC  = 14'b00000000100000,
    S_DIV_GO   = 14'b00000001000000,
    S_DIV_WAIT = 14'b00000010000000,
    S_CLAMP    = 14'b00000100000000,
    S_CHK_MUL  = 14'b00001000000000,
    S_CHK_CMP  = 14'b00010000000000,
    S_OUT_RD   = 14'b00100000000000,
    S_OUT_LD   = 14'b01000000000000,
    S_OUT_WAIT = 14'b10000000000000
  } state_e;

  state_e                 state_q;
  logic [ITER_BITS-1:0]   max_iter_q;
  logic [DELTA_BITS-1:0]  min_delta_q;
  logic                   clamp_en_q;
  logic [SIZE_BITS-1:0]   size_q;
  logic [SIZE_BITS-1:0]   n_q;
  logic [IDX_BITS-1:0]    i_q;
  logic [IDX_BITS-1:0]    j_q;
  logic [ITER_BITS-1:0]   sweep_q;
  logic                   all_small_q;
  logic                   conv_q;
  logic                   pivot_q;
  logic                   out_valid_q;

  logic signed [ACC_BITS-1:0]   acc_q;
  logic [PROD_BITS-1:0]         prod_q;
  logic                         sign_q;
  logic signed [VALUE_BITS-1:0] diag_q;
  logic signed [VALUE_BITS-1:0] old_q;
  logic signed [VALUE_BITS-1:0] fresh_q;
  logic [VALUE_BITS-1:0]        diff_q;
  logic                         qneg_q;
  logic signed [VALUE_BITS-1:0] lam_out_q;

  logic                   accept;
  logic [SIZE_BITS-1:0]   n_d;
  logic                   j_last;
  logic                   i_last;

  logic                         mat_we;
  logic [2*IDX_BITS-1:0]        mat_waddr;
  logic [2*IDX_BITS-1:0]        mat_raddr;
  logic signed [VALUE_BITS-1:0] mat_rdata;
  logic                         bnd_we;
  logic [3*VALUE_BITS-1:0]      bnd_wdata;
  logic [3*VALUE_BITS-1:0]      bnd_rdata;
  logic signed [VALUE_BITS-1:0] rhs_rd;
  logic signed [VALUE_BITS-1:0] lo_rd;
  logic signed [VALUE_BITS-1:0] hi_rd;
  logic                         lam_we;
  logic [IDX_BITS-1:0]          lam_waddr;
  logic [VALUE_BITS-1:0]        lam_wdata;
  logic [IDX_BITS-1:0]          lam_raddr;
  logic signed [VALUE_BITS-1:0] lam_rdata;
  logic                         lam_solve_we;

  logic [VALUE_BITS-1:0]        mul_a;
  logic [VALUE_BITS-1:0]        mul_b;
  logic [VALUE_BITS-1:0]        old_mag;
  logic [VALUE_BITS-1:0]        scale;
  logic signed [VALUE_BITS-1:0] term;
  logic signed [VALUE_BITS-1:0] qval;
  logic signed [VALUE_BITS-1:0] clamp_hi;
  logic signed [VALUE_BITS-1:0] clamp_res;
  logic signed [VALUE_BITS:0]   diff_full;
  logic                         row_small;
  logic                         all_small_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign n_d        = (size_q == '0) ? SIZE_BITS'(1) :
                      (size_q > SIZE_BITS'(MAX_UNKNOWNS)) ? SIZE_BITS'(MAX_UNKNOWNS) : size_q;
  assign j_last     = ({1'b0, j_q} == n_q - 1'b1);
  assign i_last     = ({1'b0, i_q} == n_q - 1'b1);

  // Storage
  assign mat_we    = accept && (mode_i == MODE_LOAD_MAT);
  assign mat_waddr = {row_i, col_i};
  assign mat_raddr = {i_q, j_q};

  pgs_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_UNKNOWNS * MAX_UNKNOWNS)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (matrix_value_i),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  assign bnd_we    = accept && (mode_i == MODE_LOAD_ROW);
  assign bnd_wdata = {rhs_value_i, limit_low_i, limit_high_i};
  assign rhs_rd    = bnd_rdata[3*VALUE_BITS-1:2*VALUE_BITS];
  assign lo_rd     = bnd_rdata[2*VALUE_BITS-1:VALUE_BITS];
  assign hi_rd     = bnd_rdata[VALUE_BITS-1:0];

  pgs_ram #(.WIDTH(3 * VALUE_BITS), .DEPTH(MAX_UNKNOWNS)) u_bnd_ram (
    .clk_i   (clk_i),
    .we_i    (bnd_we),
    .waddr_i (row_i),
    .wdata_i (bnd_wdata),
    .raddr_i (i_q),
    .rdata_o (bnd_rdata)
  );

  assign lam_solve_we = (state_q == S_CHK_CMP);
  assign lam_we    = bnd_we || lam_solve_we;
  assign lam_waddr = lam_solve_we ? i_q : row_i;
  assign lam_wdata = lam_solve_we ? fresh_q : initial_lambda_i;
  assign lam_raddr = (state_q == S_OUT_RD) ? i_q : j_q;

  pgs_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_UNKNOWNS)) u_lam_ram (
    .clk_i   (clk_i),
    .we_i    (lam_we),
    .waddr_i (lam_waddr),
    .wdata_i (lam_wdata),
    .raddr_i (lam_raddr),
    .rdata_o (lam_rdata)
  );

  // Shared multiplier: matrix by lambda products, then the convergence scale
  assign old_mag = mag_of(old_q);
  assign scale   = (old_mag < MIN_SCALE) ? MIN_SCALE : old_mag;
  assign mul_a   = (state_q == S_CHK_MUL) ? {1'b0, min_delta_q} : mag_of(mat_rdata);
  assign mul_b   = (state_q == S_CHK_MUL) ? scale : mag_of(lam_rdata);

  assign term = sat_val(prod_q[PROD_BITS-1:FRAC_BITS], sign_q);

  assign div_req.start   = (state_q == S_DIV_GO);
  assign div_req.num_mag = acc_q[ACC_BITS-1] ? (~acc_q + 1'b1) : acc_q;
  assign div_req.den_mag = mag_of(diag_q);

  pgs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign qval      = sat_val({{(SATIN_BITS-VALUE_BITS-1){1'b0}}, div_rsp.ovf, div_rsp.quot},
                             qneg_q);
  assign clamp_hi  = (clamp_en_q && (qval > hi_rd)) ? hi_rd : qval;
  assign clamp_res = (clamp_en_q && (clamp_hi < lo_rd)) ? lo_rd : clamp_hi;

  assign diff_full   = {fresh_q[VALUE_BITS-1], fresh_q} - {old_q[VALUE_BITS-1], old_q};
  assign row_small   = {{FRAC_BITS{1'b0}}, diff_q, {FRAC_BITS{1'b0}}} < prod_q;
  assign all_small_d = all_small_q && row_small;

  // Sequencer and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_iter_q  <= RST_MAX_ITER;
      min_delta_q <= RST_MIN_DELTA;
      clamp_en_q  <= 1'b1;
      size_q      <= RST_SIZE;
      n_q         <= RST_SIZE;
      i_q         <= '0;
      j_q         <= '0;
      sweep_q     <= '0;
      all_small_q <= 1'b0;
      conv_q      <= 1'b0;
      pivot_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MAX_ITER:  max_iter_q  <= cfg_data_i[ITER_BITS-1:0];
          CFG_MIN_DELTA: min_delta_q <= cfg_data_i;
          CFG_CLAMP_EN:  clamp_en_q  <= cfg_data_i[0];
          CFG_SIZE:      size_q      <= cfg_data_i[SIZE_BITS-1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept && (mode_i == MODE_SOLVE)) begin
            n_q         <= n_d;
            i_q         <= '0;
            conv_q      <= 1'b0;
            pivot_q     <= 1'b0;
            all_small_q <= 1'b1;
            if (max_iter_q == '0) begin
              sweep_q <= '0;
              state_q <= S_OUT_RD;
            end else begin
              sweep_q <= ITER_BITS'(1);
              state_q <= S_ROW;
            end
          end
        end
        S_ROW: state_q <= S_ROW_INIT;
        S_ROW_INIT: begin
          j_q     <= '0;
          state_q <= S_MAC_ADDR;
        end
        S_MAC_ADDR: state_q <= S_MAC_MUL;
        S_MAC_MUL:  state_q <= S_MAC_ACC;
        S_MAC_ACC: begin
          if (j_last) begin
            if (diag_q == '0) begin
              pivot_q <= 1'b1;
              state_q <= S_CHK_MUL;
            end else begin
              state_q <= S_DIV_GO;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_MAC_ADDR;
          end
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP:   state_q <= S_CHK_MUL;
        S_CHK_MUL: state_q <= S_CHK_CMP;
        S_CHK_CMP: begin
          if (i_last) begin
            i_q <= '0;
            if (all_small_d) begin
              conv_q  <= 1'b1;
              state_q <= S_OUT_RD;
            end else if (sweep_q == max_iter_q) begin
              state_q <= S_OUT_RD;
            end else begin
              sweep_q     <= sweep_q + 1'b1;
              all_small_q <= 1'b1;
              state_q     <= S_ROW;
            end
          end else begin
            all_small_q <= all_small_d;
            i_q         <= i_q + 1'b1;
            state_q     <= S_ROW;
          end
        end
        S_OUT_RD: state_q <= S_OUT_LD;
        S_OUT_LD: begin
          out_valid_q <= 1'b1;
          state_q     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (i_last) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_OUT_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_ROW_INIT: acc_q <= ACC_BITS'(rhs_rd);
      S_MAC_MUL: begin
        prod_q <= mul_a * mul_b;
        sign_q <= mat_rdata[VALUE_BITS-1] ^ lam_rdata[VALUE_BITS-1];
        if (j_q == i_q) begin
          diag_q <= mat_rdata;
          old_q  <= lam_rdata;
        end
      end
      S_MAC_ACC: begin
        if (j_q != i_q) begin
          acc_q <= acc_q - ACC_BITS'(term);
        end
        // a zero pivot keeps the old value
        fresh_q <= old_q;
      end
      S_DIV_GO: qneg_q <= acc_q[ACC_BITS-1] ^ diag_q[VALUE_BITS-1];
      S_CLAMP:  fresh_q <= clamp_res;
      S_CHK_MUL: begin
        prod_q <= mul_a * mul_b;
        diff_q <= diff_full[VALUE_BITS] ? VALUE_BITS'(-diff_full) : diff_full[VALUE_BITS-1:0];
      end
      S_OUT_LD: lam_out_q <= lam_rdata;
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign index_o           = i_q;
  assign lambda_value_o    = lam_out_q;
  assign converged_o       = conv_q;
  assign iterations_used_o = sweep_q;
  assign zero_pivot_o      = pivot_q;
  assign last_o            = i_last;

  `PGS_ASSERT_IMP(a_out_blocks_in, out_valid_o, !in_ready_o, "input open while a result word waits")
  `PGS_ASSERT_IMP(a_sweep_bound, state_q != S_IDLE, sweep_q <= max_iter_q, "sweep count past limit")
  `PGS_ASSERT_NXT(a_last_frees, out_valid_o && out_ready_i && last_o, in_ready_o, "not idle after last word")

endmodule

// File: hdl/pgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/pgs_div.sv
// Restoring divider, one quotient bit a cycle: (num << FRAC_BITS) / den.
// Depends on pgs_pkg.
module pgs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pgs_pkg::div_req_t req_i,
  output pgs_pkg::div_rsp_t rsp_o
);
  import pgs_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [DVD_BITS-1:0]   dvd_q;
  logic [VALUE_BITS-1:0] den_q;
  logic [VALUE_BITS-1:0] rem_q;
  logic [VALUE_BITS-1:0] quot_q;
  logic                  ovf_q;
  logic [VALUE_BITS:0]   rem_sh;
  logic                  ge;
  logic [VALUE_BITS:0]   rem_sub;

  assign rem_sh  = {rem_q, dvd_q[DVD_BITS-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(DVD_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q  <= {req_i.num_mag, {FRAC_BITS{1'b0}}};
      den_q  <= req_i.den_mag;
      rem_q  <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[DVD_BITS-2:0], 1'b0};
      rem_q  <= ge ? rem_sub[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
      quot_q <= {quot_q[VALUE_BITS-2:0], ge};
      // any bit pushed out of the top means the quotient saturates
      ovf_q  <= ovf_q | quot_q[VALUE_BITS-1];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: bench/tb_projected_gauss_seidel_solver.sv
// Self-checking testbench for the projected Gauss-Seidel solver top level.
// Predicts every lambda word in Q16.16; needs pgs_pkg and the solver RTL only.
`timescale 1ns / 100ps
module tb_projected_gauss_seidel_solver;
  import pgs_pkg::*;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam int TARGET_WORDS = 500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [DELTA_BITS-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [MODE_BITS-1:0] mode_i = '0;
  logic [IDX_BITS-1:0] row_i = '0, col_i = '0;
  logic signed [VALUE_BITS-1:0] matrix_value_i = '0, rhs_value_i = '0;
  logic signed [VALUE_BITS-1:0] limit_low_i = '0, limit_high_i = '0, initial_lambda_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [IDX_BITS-1:0] index_o;
  logic signed [VALUE_BITS-1:0] lambda_value_o;
  logic converged_o, zero_pivot_o, last_o;
  logic [ITER_BITS-1:0] iterations_used_o;

  projected_gauss_seidel_solver dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  typedef struct {
    logic [IDX_BITS-1:0] index;
    logic [VALUE_BITS-1:0] lambda;
    logic converged;
    logic [ITER_BITS-1:0] iters;
    logic zero_pivot;
    logic last;
  } lambda_word_t;

  lambda_word_t lambda_fifo[$];
  int errors = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  // solver state as the block should hold it
  longint mat_q[MAX_UNKNOWNS][MAX_UNKNOWNS];
  longint rhs_q[MAX_UNKNOWNS], lo_q[MAX_UNKNOWNS], hi_q[MAX_UNKNOWNS];
  longint lam_q[MAX_UNKNOWNS];
  int unsigned cfg_max_iter = 128, cfg_size = 16;
  bit [63:0] cfg_min_delta = 64'd6554;
  bit cfg_clamp = 1'b1;

  function automatic bit [63:0] mag64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint sat_signed(bit [63:0] m, bit neg);
    if (neg) return (m > 64'h8000_0000) ? QMIN : -longint'(m);
    return (m > 64'h7FFF_FFFF) ? QMAX : longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    bit [63:0] p;
    p = mag64(a) * mag64(b);
    return sat_signed(p >> FRAC_BITS, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint num, longint den);
    bit [63:0] un, ud, whole, rest, m;
    un = mag64(num);
    ud = mag64(den);
    whole = un / ud;
    rest = un % ud;
    if (whole >= 64'h1_0000) m = 64'h8000_0001;
    else m = (whole << FRAC_BITS) + ((rest << FRAC_BITS) / ud);
    return sat_signed(m, (num < 0) != (den < 0));
  endfunction

  function automatic bit change_small(longint fresh, longint old);
    bit [63:0] diff, scale;
    diff = mag64(fresh - old);
    scale = mag64(old);
    if (scale < 64'd66) scale = 64'd66;
    return (diff << FRAC_BITS) < (cfg_min_delta * scale);
  endfunction

  function automatic void solve_lambdas();
    int unsigned n, sweeps;
    bit conv, zp, all_small;
    longint acc, fresh, old;
    lambda_word_t w;
    n = cfg_size;
    if (n < 1) n = 1;
    if (n > MAX_UNKNOWNS) n = MAX_UNKNOWNS;
    sweeps = 0;
    conv = 0;
    zp = 0;
    for (int s = 0; s < cfg_max_iter; s++) begin
      all_small = 1;
      sweeps++;
      for (int i = 0; i < n; i++) begin
        old = lam_q[i];
        acc = rhs_q[i];
        if (mat_q[i][i] == 0) begin
          zp = 1;
          fresh = old;
        end else begin
          for (int j = 0; j < n; j++)
            if (j != i) acc -= fx_mul(mat_q[i][j], lam_q[j]);
          fresh = fx_div(acc, mat_q[i][i]);
          if (cfg_clamp) begin
            if (fresh > hi_q[i]) fresh = hi_q[i];
            if (fresh < lo_q[i]) fresh = lo_q[i];
          end
        end
        if (!change_small(fresh, old)) all_small = 0;
        lam_q[i] = fresh;
      end
      if (all_small) begin
        conv = 1;
        break;
      end
    end
    for (int i = 0; i < n; i++) begin
      w.index = i[IDX_BITS-1:0];
      w.lambda = lam_q[i][31:0];
      w.converged = conv;
      w.iters = sweeps[ITER_BITS-1:0];
      w.zero_pivot = zp;
      w.last = (i + 1 == n);
      lambda_fifo.push_back(w);
    end
  endfunction

  // Offer one word; returns at the edge that accepts it, valid still high.
  task automatic send_word(mode_e m, int r, int c, logic [31:0] mv, logic [31:0] rv,
                           logic [31:0] lo, logic [31:0] hi, logic [31:0] lam);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= m;
    row_i <= r[IDX_BITS-1:0];
    col_i <= c[IDX_BITS-1:0];
    matrix_value_i <= mv;
    rhs_value_i <= rv;
    limit_low_i <= lo;
    limit_high_i <= hi;
    initial_lambda_i <= lam;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    case (m)
      MODE_LOAD_MAT: mat_q[r[3:0]][c[3:0]] = longint'(signed'(mv));
      MODE_LOAD_ROW: begin
        rhs_q[r[3:0]] = longint'(signed'(rv));
        lo_q[r[3:0]] = longint'(signed'(lo));
        hi_q[r[3:0]] = longint'(signed'(hi));
        lam_q[r[3:0]] = longint'(signed'(lam));
      end
      MODE_SOLVE: solve_lambdas();
      default: ;
    endcase
  endtask

  task automatic send_mat(int r, int c, logic [31:0] v);
    send_word(MODE_LOAD_MAT, r, c, v, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_row(int r, logic [31:0] rv, logic [31:0] lo, logic [31:0] hi,
                          logic [31:0] lam);
    send_word(MODE_LOAD_ROW, r, $urandom_range(15), $urandom, rv, lo, hi, lam);
  endtask

  task automatic send_solve();
    send_word(MODE_SOLVE, $urandom_range(15), $urandom_range(15), $urandom, $urandom,
              $urandom, $urandom, $urandom);
  endtask

  // Drop valid, drain all lambdas, then let the block settle.
  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    wait (lambda_fifo.size() == 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v[DELTA_BITS-1:0];
    @(negedge clk_i) cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_ITER: cfg_max_iter = v & 32'h3FF;
      CFG_MIN_DELTA: cfg_min_delta = v & 32'h7FFF_FFFF;
      CFG_CLAMP_EN: cfg_clamp = v[0];
      CFG_SIZE: cfg_size = v & 32'h1F;
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned iters, int unsigned delta, bit clamp,
                            int unsigned size);
    drain();
    write_reg(CFG_MAX_ITER, iters);
    write_reg(CFG_MIN_DELTA, delta);
    write_reg(CFG_CLAMP_EN, clamp);
    write_reg(CFG_SIZE, size);
  endtask

  function automatic logic [31:0] small_val(int unsigned span);
    int v;
    v = $urandom_range(span);
    return $urandom_range(1) ? -v : v;
  endfunction

  // Random system on the first n rows: off-diagonals mostly small, diagonal a small integer.
  task automatic load_system(int n, int noise_pct);
    logic [31:0] lo, hi, dv;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        if ($urandom_range(99) < noise_pct)
          send_word(MODE_NONE, $urandom_range(15), $urandom_range(15), $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        dv = small_val(6);
        if (r == c) send_mat(r, c, {dv[15:0], 16'h0} + 32'h0002_0000);
        else if ($urandom_range(99) < noise_pct) send_mat(r, c, $urandom);
        else send_mat(r, c, small_val(32'h6000));
      end
    for (int r = 0; r < n; r++) begin
      lo = small_val(32'h40000);
      hi = lo + $urandom_range(32'h80000);
      if ($urandom_range(99) < noise_pct) send_row(r, $urandom, $urandom, $urandom, $urandom);
      else send_row(r, small_val(32'h80000), lo, hi, small_val(32'h20000));
    end
  endtask

  // every store entry gets written once so no solve reads garbage
  task automatic test_full_load();
    set_config(128, 6554, 1, 16);
    load_system(MAX_UNKNOWNS, 0);
    send_solve();
  endtask

  task automatic test_field_extremes();
    set_config(4, 6554, 1, 2);
    send_mat(0, 0, 32'h7FFF_FFFF);
    send_mat(0, 1, 32'h8000_0000);
    send_mat(1, 0, 32'h7FFF_FFFF);
    send_mat(1, 1, 32'h8000_0000);
    send_row(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_row(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_solve();
    set_config(4, 6554, 0, 2);
    send_mat(1, 1, 32'h0000_0001);
    send_row(0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_solve();
  endtask

  task automatic test_zero_pivot_and_crossed_limits();
    set_config(8, 6554, 1, 3);
    send_mat(1, 1, 32'h0);
    send_row(0, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'h0);
    send_solve();
    send_word(MODE_NONE, 2, 2, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_register_edges();
    set_config(0, 6554, 1, 4);
    send_solve();
    set_config(1, 32'h7FFF_FFFF, 1, 0);
    send_solve();
    set_config(3, 0, 0, 31);
    send_solve();
    set_config(1023, 0, 1, 1);
    send_mat(0, 0, 32'h0002_0000);
    send_solve();
    set_config(1023, 6554, 1, 17);
    send_solve();
  endtask

  // Receiver holds off while the sender keeps offering words, then the
  // sender waits for every lambda before going on.
  task automatic test_backpressure();
    set_config(6, 6554, 1, 4);
    hold_cycles = 3000;
    send_solve();
    for (int k = 0; k < 4; k++) send_row(k, small_val(32'h30000), 32'hFFFF_0000,
                                         32'h0001_0000, 32'h0);
    send_solve();
    drain();
    send_solve();
  endtask

  task automatic test_random_systems();
    int n, iters, delta, start;
    start = words_sent;
    while (words_sent < TARGET_WORDS) begin
      if (words_sent - start < (TARGET_WORDS - start) / 3) begin
        send_idle_pct = 23;
        recv_stall_pct = 78;
      end else if (words_sent - start < 2 * (TARGET_WORDS - start) / 3) begin
        send_idle_pct = 78;
        recv_stall_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(MAX_UNKNOWNS, 5);
        iters = $urandom_range(3, 1);
      end else begin
        n = $urandom_range(4, 1);
        iters = $urandom_range(24, 1);
      end
      case ($urandom_range(3))
        0: delta = $urandom_range(200);
        1: delta = 6554;
        2: delta = $urandom_range(32'h7FFF_FFFF);
        default: delta = $urandom_range(32'h4_0000);
      endcase
      set_config(iters, delta, $urandom_range(1), n);
      if ($urandom_range(4) == 0) begin
        // broken sequence: a few stray loads over the rows in use
        repeat ($urandom_range(4)) send_mat($urandom_range(n - 1), $urandom_range(n - 1),
                                            $urandom);
        repeat ($urandom_range(2)) send_row($urandom_range(n - 1), $urandom, $urandom,
                                            $urandom, $urandom);
      end else begin
        load_system(n, 10);
      end
      send_solve();
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lambda_fifo.size() == 0) begin
        $error("unexpected lambda word, index %0d", index_o);
        errors++;
      end else begin
        lambda_word_t w;
        w = lambda_fifo.pop_front();
        if (index_o !== w.index) begin
          $error("index: expected %0d, got %0d", w.index, index_o);
          errors++;
        end
        if (lambda_value_o !== w.lambda) begin
          $error("lambda_value: expected %h, got %h", w.lambda, lambda_value_o);
          errors++;
        end
        if (converged_o !== w.converged) begin
          $error("converged: expected %b, got %b", w.converged, converged_o);
          errors++;
        end
        if (iterations_used_o !== w.iters) begin
          $error("iterations_used: expected %0d, got %0d", w.iters, iterations_used_o);
          errors++;
        end
        if (zero_pivot_o !== w.zero_pivot) begin
          $error("zero_pivot: expected %b, got %b", w.zero_pivot, zero_pivot_o);
          errors++;
        end
        if (last_o !== w.last) begin
          $error("last: expected %b, got %b", w.last, last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    send_idle_pct = 23;
    recv_stall_pct = 78;
    test_full_load();
    test_field_extremes();
    test_zero_pivot_and_crossed_limits();
    test_register_edges();
    test_backpressure();
    test_random_systems();
    drain();
    repeat (50) @(posedge clk_i);
    if (lambda_fifo.size() != 0) begin
      $error("%0d lambda words never arrived", lambda_fifo.size());
      errors++;
    end
    if (errors == 0) $display("[projected_gauss_seidel_solver] OK");
    else $display("[projected_gauss_seidel_solver] ERROR");
    $finish;
  end

  initial begin
    #(64'd1_000_000_000);
    $display("[projected_gauss_seidel_solver] ERROR");
    $finish;
  end

endmodule
